[src/cace_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cace_pkg: shared types and constants of the credit aging cache evictor
// Operation and status codes, register indexes, controller states and the
// fixed widths and reset values of the configuration registers.
// ----------------------------------------------------------------------------
package cace_pkg;

   localparam int CFG_W      = 11;  // widest configuration register
   localparam int CHUNK_W    = 7;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CHUNK_W-1:0] MAX_CHUNK = 7'd64;
   localparam logic [CHUNK_W-1:0] MIN_CHUNK = 7'd1;

   localparam logic [CFG_W-1:0]   MIN_ALIVE_RESET    = 11'd500;
   localparam logic [CHUNK_W-1:0] CHUNK_SIZE_RESET   = 7'd64;
   localparam logic [CFG_W-1:0]   LOAD_CREDITS_RESET = 11'd100;
   localparam logic [CFG_W-1:0]   HIT_CREDITS_RESET  = 11'd1024;

   // hit update: credits = (hit_credits + credits * HIT_DECAY) >> HIT_SHIFT
   localparam int HIT_DECAY = 253;
   localparam int HIT_SHIFT = 8;

   typedef enum logic [1:0] {
      KIND_ADD     = 2'd0,
      KIND_ACCESS  = 2'd1,
      KIND_UNLOAD  = 2'd2,
      KIND_COLLECT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_RANGE   = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_INVALID = 2'd3
   } status_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MIN_ALIVE    = 2'd0,
      CSR_CHUNK_SIZE   = 2'd1,
      CSR_LOAD_CREDITS = 2'd2,
      CSR_HIT_CREDITS  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP_RD,
      ST_SWEEP_WR,
      ST_SWEEP_END
   } state_type;

endpackage
`default_nettype wire

[src/cace_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cace_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds
// its value until the next read.
// ----------------------------------------------------------------------------
module cace_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[src/cace_credit_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cace_credit_alu: credit arithmetic of one entry
// Hit decay with saturation, saturated load value, and aging by one credit
// that bottoms out at -1.
// ----------------------------------------------------------------------------
module cace_credit_alu
   import cace_pkg::*;
#(
   parameter int CREDIT_BITS = 12
) (
   input  wire logic signed [CREDIT_BITS-1:0] credits_in,
   input  wire logic        [CFG_W-1:0]       hit_credits,
   input  wire logic        [CFG_W-1:0]       load_credits,
   output logic signed      [CREDIT_BITS-1:0] hit_value,
   output logic signed      [CREDIT_BITS-1:0] load_value,
   output logic signed      [CREDIT_BITS-1:0] aged_value
);

   localparam int SUM_W = CREDIT_BITS + 10;

   localparam logic signed [SUM_W-1:0] DECAY = SUM_W'(HIT_DECAY);
   localparam logic signed [SUM_W-1:0] CRED_MAX =
      {{(SUM_W-CREDIT_BITS+1){1'b0}}, {(CREDIT_BITS-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] CRED_MIN =
      {{(SUM_W-CREDIT_BITS+1){1'b1}}, {(CREDIT_BITS-1){1'b0}}};

   logic signed [SUM_W-1:0] credits_ext;
   logic signed [SUM_W-1:0] hit_ext;
   logic signed [SUM_W-1:0] load_ext;
   logic signed [SUM_W-1:0] decay_sum;
   logic signed [SUM_W-1:0] decay_shr;

   function automatic logic signed [CREDIT_BITS-1:0] sat_credit(
      input logic signed [SUM_W-1:0] v
   );
      logic signed [CREDIT_BITS-1:0] r;
      if (v > CRED_MAX) begin
         r = CRED_MAX[CREDIT_BITS-1:0];
      end else if (v < CRED_MIN) begin
         r = CRED_MIN[CREDIT_BITS-1:0];
      end else begin
         r = v[CREDIT_BITS-1:0];
      end
      return r;
   endfunction

   assign credits_ext = SUM_W'(credits_in);
   assign hit_ext     = signed'(SUM_W'(hit_credits));
   assign load_ext    = signed'(SUM_W'(load_credits));

   // arithmetic shift gives the floor of the division for negative sums
   assign decay_sum = credits_ext * DECAY + hit_ext;
   assign decay_shr = decay_sum >>> HIT_SHIFT;

   assign hit_value  = sat_credit(decay_shr);
   assign load_value = sat_credit(load_ext);

   // negative credits settle at -1; anything else drops by one
   assign aged_value = credits_in[CREDIT_BITS-1] ? '1 : credits_in - CREDIT_BITS'(1);

endmodule
`default_nettype wire

[src/credit_aging_cache_evictor.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// credit_aging_cache_evictor: aging-credit cache replacement table
// Entry table in one RAM, a controller for add, access, unload and collect,
// and a registered result stage.
// ----------------------------------------------------------------------------
// Entry state (loaded, reloadable, credits) lives in one single-port-read
// RAM with a registered read; the fill count keeps entries beyond the table
// end from ever being read, and the cycle after reset writes the sentinel
// entry 0, during which no transaction is accepted. ACCESS and UNLOAD read
// the entry on accept; ST_EXEC, once the result register has room,
// modifies it, writes it back and loads the result register (ADD writes a
// new entry). Below the alive threshold a COLLECT does no sweep; else it
// sweeps up to 64 entries of one chunk: ST_SWEEP_RD reads each, ST_SWEEP_WR
// ages and writes it back; ST_SWEEP_END closes. Evictions found during a
// sweep are held one deep so the final one can carry tlast. The result
// register lets a new transaction be accepted while a result waits; the
// block stalls only when it must present a result and the register is full.
// ----------------------------------------------------------------------------
module credit_aging_cache_evictor
   import cace_pkg::*;
#(
   parameter int NUM_ENTRIES = 1024,
   parameter int CREDIT_BITS = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: entry_index, can_reload, arrives_loaded, load_ok
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [((($clog2(NUM_ENTRIES)+3)+7)/8)*8-1:0] req_tdata,
   // req_tuser: kind
   input  wire logic [1:0]                        req_tuser,
   // rsp_tdata: status, result_index, was_hit, evicted, alive_count,
   //            loadable_count, dummy_count
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [((2+$clog2(NUM_ENTRIES)+2+3*$clog2(NUM_ENTRIES+1))+7)/8*8-1:0] rsp_tdata,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_we,
   input  wire logic [CSR_ADDR_W-1:0]             csr_addr,
   input  wire logic [CFG_W-1:0]                  csr_wdata
);

   localparam int IDX_W   = $clog2(NUM_ENTRIES);
   localparam int CNT_W   = $clog2(NUM_ENTRIES + 1);
   localparam int ENTRY_W = CREDIT_BITS + 2;
   localparam int RSP_W   = ((2 + IDX_W + 2 + 3*CNT_W) + 7) / 8 * 8;
   localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int SP_W    = ((CNT_W > CHUNK_W) ? CNT_W : CHUNK_W) + 1;
   localparam int LOADED_BIT = CREDIT_BITS + 1;
   localparam int RELOAD_BIT = CREDIT_BITS;

   localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(NUM_ENTRIES);

   // ---------------------------------------------------------------- state
   state_type state_ff, state_in;

   logic [CFG_W-1:0]   min_alive_ff, load_credits_ff, hit_credits_ff;
   logic [CHUNK_W-1:0] chunk_size_ff;

   kind_type         op_kind_ff, op_kind_in;
   status_type       op_status_ff, op_status_in;
   logic [IDX_W-1:0] op_index_ff, op_index_in;
   logic             op_can_reload_ff, op_can_reload_in;
   logic             op_arrives_ff, op_arrives_in;
   logic             op_load_ok_ff, op_load_ok_in;

   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   logic [CNT_W-1:0] alive_ff, alive_in;
   logic [CNT_W-1:0] loadable_ff, loadable_in;
   logic [CNT_W-1:0] dummy_ff, dummy_in;
   logic [CNT_W-1:0] sweep_start_ff, sweep_start_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] sweep_end_ff, sweep_end_in;

   logic             pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0] pend_index_ff, pend_index_in;
   logic [CNT_W-1:0] pend_alive_ff, pend_alive_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   // ------------------------------------------------------------ RAM port
   logic               ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;

   cace_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   logic signed [CREDIT_BITS-1:0] rd_credits, hit_value, load_value, aged_value;
   logic                          rd_loaded, rd_reloadable;

   assign rd_credits    = signed'(ram_rd_data[CREDIT_BITS-1:0]);
   assign rd_loaded     = ram_rd_data[LOADED_BIT];
   assign rd_reloadable = ram_rd_data[RELOAD_BIT];

   cace_credit_alu #(
      .CREDIT_BITS (CREDIT_BITS)
   ) u_credit_alu (
      .credits_in   (rd_credits),
      .hit_credits  (hit_credits_ff),
      .load_credits (load_credits_ff),
      .hit_value    (hit_value),
      .load_value   (load_value),
      .aged_value   (aged_value)
   );

   // ------------------------------------------------------- shared decode
   logic             req_accept, out_room;
   kind_type         in_kind;
   logic [IDX_W-1:0] in_index;
   logic             in_can_reload, in_arrives, in_load_ok, in_range;
   logic             collect_idle;
   logic             sw_evict, sw_stall;
   logic [CHUNK_W-1:0] chunk_eff;
   logic [CNT_W-1:0] sweep_first;
   logic [SP_W-1:0]  sweep_limit;

   assign req_tready    = (state_ff == ST_IDLE);
   assign req_accept    = req_tvalid && req_tready;
   assign out_room      = !rsp_valid_ff || rsp_tready;

   assign in_kind       = kind_type'(req_tuser);
   assign in_index      = req_tdata[IDX_W-1:0];
   assign in_can_reload = req_tdata[IDX_W];
   assign in_arrives    = req_tdata[IDX_W+1];
   assign in_load_ok    = req_tdata[IDX_W+2];
   assign in_range      = CNT_W'(in_index) < entry_count_ff;
   assign collect_idle  = CMP_W'(alive_ff) < CMP_W'(min_alive_ff);

   assign chunk_eff = (chunk_size_ff < MIN_CHUNK) ? MIN_CHUNK :
                      (chunk_size_ff > MAX_CHUNK) ? MAX_CHUNK : chunk_size_ff;
   assign sweep_first = (sweep_start_ff > entry_count_ff) ? entry_count_ff
                                                          : sweep_start_ff;
   assign sweep_limit = SP_W'(sweep_first) + SP_W'(chunk_eff);

   // an eviction that must push out the held one stalls on a full result slot
   assign sw_evict = rd_reloadable && rd_loaded && aged_value[CREDIT_BITS-1];
   assign sw_stall = sw_evict && pend_valid_ff && !out_room;

   // ----------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (in_kind != KIND_COLLECT) begin
                  state_in = ST_EXEC;
               end else if (!collect_idle) begin
                  state_in = ST_SWEEP_RD;
               end
            end
         end
         ST_EXEC: begin
            if (out_room) state_in = ST_IDLE;
         end
         ST_SWEEP_RD: begin
            state_in = (cur_ff == sweep_end_ff) ? ST_SWEEP_END : ST_SWEEP_WR;
         end
         ST_SWEEP_WR: begin
            if (!sw_stall) state_in = ST_SWEEP_RD;
         end
         ST_SWEEP_END: begin
            if (!pend_valid_ff || out_room) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // -------------------------------------------------------------- outputs
   logic             emit_en, emit_hit, emit_evicted, emit_last;
   status_type       emit_status;
   logic [IDX_W-1:0] emit_index;
   logic [CNT_W-1:0] emit_alive;

   always_comb begin
      op_kind_in       = op_kind_ff;
      op_status_in     = op_status_ff;
      op_index_in      = op_index_ff;
      op_can_reload_in = op_can_reload_ff;
      op_arrives_in    = op_arrives_ff;
      op_load_ok_in    = op_load_ok_ff;
      entry_count_in   = entry_count_ff;
      alive_in         = alive_ff;
      loadable_in      = loadable_ff;
      dummy_in         = dummy_ff;
      sweep_start_in   = sweep_start_ff;
      cur_in           = cur_ff;
      sweep_end_in     = sweep_end_ff;
      pend_valid_in    = pend_valid_ff;
      pend_index_in    = pend_index_ff;
      pend_alive_in    = pend_alive_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = op_index_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = in_index;

      emit_en      = 1'b0;
      emit_status  = STATUS_OK;
      emit_index   = op_index_ff;
      emit_hit     = 1'b0;
      emit_evicted = 1'b0;
      emit_last    = 1'b1;

      unique case (state_ff)
         ST_INIT: begin
            // sentinel: loaded, never reloadable
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            ram_wr_data = {1'b1, 1'b0, {CREDIT_BITS{1'b0}}};
         end

         ST_IDLE: begin
            if (req_accept) begin
               op_kind_in       = in_kind;
               op_index_in      = in_index;
               op_can_reload_in = in_can_reload;
               op_arrives_in    = in_arrives;
               op_load_ok_in    = in_load_ok;
               op_status_in     = STATUS_OK;
               unique case (in_kind)
                  KIND_ADD: begin
                     if (!in_can_reload && !in_arrives) begin
                        op_status_in = STATUS_INVALID;
                     end else if (entry_count_ff == TABLE_FULL) begin
                        op_status_in = STATUS_FULL;
                     end
                  end
                  KIND_ACCESS, KIND_UNLOAD: begin
                     if (in_range) begin
                        ram_rd_en = 1'b1;
                     end else begin
                        op_status_in = STATUS_RANGE;
                     end
                  end
                  KIND_COLLECT: begin
                     if (!collect_idle) begin
                        cur_in = sweep_first;
                        if (sweep_limit > SP_W'(entry_count_ff)) begin
                           sweep_end_in   = entry_count_ff;
                           sweep_start_in = '0;
                        end else begin
                           sweep_end_in   = sweep_limit[CNT_W-1:0];
                           sweep_start_in = sweep_limit[CNT_W-1:0];
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_EXEC: begin
            if (out_room) begin
               emit_en = 1'b1;
               if (op_status_ff != STATUS_OK) begin
                  emit_status = op_status_ff;
                  emit_index  = (op_kind_ff == KIND_ADD) ? '0 : op_index_ff;
               end else begin
                  unique case (op_kind_ff)
                     KIND_ADD: begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = entry_count_ff[IDX_W-1:0];
                        ram_wr_data = {op_arrives_ff, op_can_reload_ff,
                                       op_arrives_ff ? load_value : '0};
                        emit_index     = entry_count_ff[IDX_W-1:0];
                        entry_count_in = entry_count_ff + CNT_W'(1);
                        if (op_can_reload_ff) loadable_in = loadable_ff + CNT_W'(1);
                        if (op_arrives_ff) alive_in = alive_ff + CNT_W'(1);
                     end
                     KIND_ACCESS: begin
                        ram_wr_en = 1'b1;
                        if (rd_loaded) begin
                           ram_wr_data = {1'b1, rd_reloadable, hit_value};
                           emit_hit    = 1'b1;
                        end else begin
                           ram_wr_data = {1'b1, rd_reloadable && op_load_ok_ff,
                                          load_value};
                           alive_in    = alive_ff + CNT_W'(1);
                           if (!op_load_ok_ff) begin
                              dummy_in = dummy_ff + CNT_W'(1);
                              if (rd_reloadable && loadable_ff != '0) begin
                                 loadable_in = loadable_ff - CNT_W'(1);
                              end
                           end
                        end
                     end
                     KIND_UNLOAD: begin
                        if (rd_reloadable && rd_loaded) begin
                           ram_wr_en    = 1'b1;
                           ram_wr_data  = {1'b0, 1'b1, rd_credits};
                           emit_evicted = 1'b1;
                           if (alive_ff != '0) alive_in = alive_ff - CNT_W'(1);
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end

         ST_SWEEP_RD: begin
            if (cur_ff != sweep_end_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cur_ff[IDX_W-1:0];
            end
         end

         ST_SWEEP_WR: begin
            if (!sw_stall) begin
               cur_in = cur_ff + CNT_W'(1);
               if (rd_reloadable) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = cur_ff[IDX_W-1:0];
                  ram_wr_data = {rd_loaded && !aged_value[CREDIT_BITS-1], 1'b1,
                                 aged_value};
               end
               if (sw_evict) begin
                  if (alive_ff != '0) alive_in = alive_ff - CNT_W'(1);
                  // release the held eviction; this one becomes the held one
                  if (pend_valid_ff) begin
                     emit_en      = 1'b1;
                     emit_index   = pend_index_ff;
                     emit_evicted = 1'b1;
                     emit_last    = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_index_in = cur_ff[IDX_W-1:0];
                  pend_alive_in = alive_in;
               end
            end
         end

         ST_SWEEP_END: begin
            if (pend_valid_ff && out_room) begin
               emit_en       = 1'b1;
               emit_index    = pend_index_ff;
               emit_evicted  = 1'b1;
               pend_valid_in = 1'b0;
            end
         end

         default: ;
      endcase

      emit_alive = (state_ff == ST_EXEC) ? alive_in : pend_alive_ff;
   end

   // --------------------------------------------------------- result stage
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_en) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({dummy_in, loadable_in, emit_alive, emit_evicted,
                                emit_hit, emit_index, emit_status});
         rsp_last_in  = emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_INIT;
         min_alive_ff    <= MIN_ALIVE_RESET;
         chunk_size_ff   <= CHUNK_SIZE_RESET;
         load_credits_ff <= LOAD_CREDITS_RESET;
         hit_credits_ff  <= HIT_CREDITS_RESET;
         entry_count_ff  <= CNT_W'(1);
         alive_ff        <= '0;
         loadable_ff     <= '0;
         dummy_ff        <= '0;
         sweep_start_ff  <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         alive_ff       <= alive_in;
         loadable_ff    <= loadable_in;
         dummy_ff       <= dummy_in;
         sweep_start_ff <= sweep_start_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_addr))
               CSR_MIN_ALIVE:    min_alive_ff    <= csr_wdata;
               CSR_CHUNK_SIZE:   chunk_size_ff   <= csr_wdata[CHUNK_W-1:0];
               CSR_LOAD_CREDITS: load_credits_ff <= csr_wdata;
               CSR_HIT_CREDITS:  hit_credits_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_kind_ff       <= op_kind_in;
      op_status_ff     <= op_status_in;
      op_index_ff      <= op_index_in;
      op_can_reload_ff <= op_can_reload_in;
      op_arrives_ff    <= op_arrives_in;
      op_load_ok_ff    <= op_load_ok_in;
      cur_ff           <= cur_in;
      sweep_end_ff     <= sweep_end_in;
      pend_index_ff    <= pend_index_in;
      pend_alive_ff    <= pend_alive_in;
      rsp_data_ff      <= rsp_data_in;
      rsp_last_ff      <= rsp_last_in;
   end

endmodule
`default_nettype wire
